// File: rtl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg: shared types and constants for the array list engine
// Action codes, status codes and the front-to-back command word.
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int DEPTH_DEF  = 32;
    localparam int WIDTH_DEF  = 32;
    localparam int QDEPTH_DEF = 2;   // command queue depth
    localparam int AW         = 4;   // action field width
    localparam int VW         = 32;  // value and key field width
    localparam int PW         = 6;   // position and count field width
    localparam int IW         = 5;   // index field width
    localparam int SW         = 2;   // status field width

    typedef enum logic [AW-1:0] {
        ACT_CLEAR      = 4'd0,
        ACT_APPEND     = 4'd1,
        ACT_INSERT_AT  = 4'd2,
        ACT_DELETE_AT  = 4'd3,
        ACT_DELETE_VAL = 4'd4,
        ACT_SEARCH     = 4'd5,
        ACT_READ_AT    = 4'd6,
        ACT_INS_SORTED = 4'd7,
        ACT_INS_BEFORE = 4'd8,
        ACT_DUMP       = 4'd9,
        ACT_DUMP_REV   = 4'd10
    } t_action;

    typedef enum logic [SW-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_POS  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // classified command handed from front to back
    typedef struct packed {
        logic [AW-1:0] action;
        logic          known;
        logic [VW-1:0] value;
        logic [VW-1:0] key;
        logic [PW-1:0] position;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_MATCH,
        S_SORT_INIT,
        S_SORT_LD,
        S_SORT_CMP,
        S_SORT_END,
        S_SHUP_RD,
        S_SHUP_WR,
        S_SHDN_RD,
        S_SHDN_WR,
        S_READ,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_EMIT
    } t_state;

endpackage

// File: rtl/ale_front.sv
// ----------------------------------------------------------------------------
// ale_front: input stage and command queue
// Accepts words, tags known actions and holds them in a short queue.
// ----------------------------------------------------------------------------
module ale_front #(
    parameter int QDEPTH = ale_pkg::QDEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [ale_pkg::AW-1:0] i_action,
    input  logic [ale_pkg::VW-1:0] i_value,
    input  logic [ale_pkg::VW-1:0] i_key,
    input  logic [ale_pkg::PW-1:0] i_position,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output ale_pkg::t_cmd        o_cmd
);
    localparam int QA = $clog2(QDEPTH);

    ale_pkg::t_cmd r_q [QDEPTH];
    logic [QA-1:0] r_wp, r_rp;
    logic [QA:0]   r_cnt;
    ale_pkg::t_cmd w_in;
    logic          w_push, w_pop;

    assign o_ready     = (r_cnt != (QA+1)'(QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        w_in.action   = i_action;
        w_in.known    = (i_action <= 4'(ale_pkg::ACT_DUMP_REV));
        w_in.value    = i_value;
        w_in.key      = i_key;
        w_in.position = i_position;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == QA'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == QA'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (QA+1)'(w_push) - (QA+1)'(w_pop);
        end
    end
endmodule

// File: rtl/ale_back.sv
// ----------------------------------------------------------------------------
// ale_back: list sequencer
// Walks the element memory one entry per step and emits result words.
// ----------------------------------------------------------------------------
module ale_back #(
    parameter int DEPTH = ale_pkg::DEPTH_DEF,
    parameter int WIDTH = ale_pkg::WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    output logic                   o_cmd_ready,
    input  ale_pkg::t_cmd          i_cmd,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [ale_pkg::SW-1:0] o_status,
    output logic [ale_pkg::IW-1:0] o_index,
    output logic [ale_pkg::VW-1:0] o_data,
    output logic [ale_pkg::PW-1:0] o_count,
    output logic                   o_last
);
    localparam int AB = $clog2(DEPTH);
    localparam int CB = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;
    logic [WIDTH-1:0] r_hold;        // element carried along a sort pass

    ale_pkg::t_state r_state, n_state;
    ale_pkg::t_cmd   r_cmd;
    logic [CB-1:0]   r_count, n_count;
    logic [CB-1:0]   r_i, n_i;       // walk index
    logic [CB-1:0]   r_lim, n_lim;   // sort pass bound
    logic [CB-1:0]   r_tgt, n_tgt;   // target position
    logic [ale_pkg::SW-1:0] r_st, n_st;

    // memory port controls
    logic            w_we;
    logic [AB-1:0]   w_wa, w_ra;
    logic [WIDTH-1:0] w_wd;
    logic [CB-1:0]   w_dump_i;

    // output register
    logic            r_ov;
    logic [ale_pkg::SW-1:0] r_os;
    logic [ale_pkg::IW-1:0] r_oi;
    logic [ale_pkg::VW-1:0] r_od;
    logic [ale_pkg::PW-1:0] r_oc;
    logic            r_ol;
    logic            w_emit;
    logic [ale_pkg::SW-1:0] w_es;
    logic [ale_pkg::IW-1:0] w_ei;
    logic [ale_pkg::VW-1:0] w_ed;
    logic            w_el;

    logic [WIDTH-1:0] w_val, w_key;
    logic             w_full;
    logic             w_oslot;
    logic             w_less;        // sort: next entry below carried one
    logic             w_hit;         // search match
    logic             w_ge;          // sorted insert: entry not below value

    assign w_val   = WIDTH'($signed(r_cmd.value));
    assign w_key   = WIDTH'($signed(r_cmd.key));
    assign w_full  = (r_count == CB'(DEPTH));
    assign w_oslot = !r_ov || i_ready;
    assign w_less  = ($signed(r_rd) < $signed(r_hold));
    assign w_hit   = (r_rd == ((r_cmd.action == ale_pkg::ACT_DELETE_VAL) ? w_val : w_key));
    assign w_ge    = !($signed(r_rd) < $signed(w_val));
    assign w_dump_i = (r_cmd.action == ale_pkg::ACT_DUMP) ? r_i
                      : r_count - 1'b1 - r_i;

    assign o_cmd_ready = (r_state == ale_pkg::S_IDLE);
    assign o_valid  = r_ov;
    assign o_status = r_os;
    assign o_index  = r_oi;
    assign o_data   = r_od;
    assign o_count  = r_oc;
    assign o_last   = r_ol;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_ra];
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_i = r_i; n_lim = r_lim; n_tgt = r_tgt; n_st = r_st;
        case (r_state)
            ale_pkg::S_IDLE: begin
                n_i = '0; n_st = ale_pkg::ST_OK; n_tgt = '0;
                if (i_cmd_valid) begin
                    n_state = ale_pkg::S_EMIT;
                    if (i_cmd.known) begin
                        case (ale_pkg::t_action'(i_cmd.action))
                            ale_pkg::ACT_CLEAR: n_count = '0;
                            ale_pkg::ACT_APPEND: begin
                                if (w_full) n_st = ale_pkg::ST_FULL;
                                else begin
                                    n_tgt = r_count; n_i = r_count;
                                    n_state = ale_pkg::S_SHUP_WR;
                                end
                            end
                            ale_pkg::ACT_INSERT_AT: begin
                                if ({1'b0, i_cmd.position} > 7'(r_count))
                                    n_st = ale_pkg::ST_BAD_POS;
                                else if (w_full) n_st = ale_pkg::ST_FULL;
                                else begin
                                    n_tgt = CB'(i_cmd.position); n_i = r_count;
                                    n_state = ale_pkg::S_SHUP_RD;
                                end
                            end
                            ale_pkg::ACT_DELETE_AT, ale_pkg::ACT_READ_AT: begin
                                if ({1'b0, i_cmd.position} >= 7'(r_count))
                                    n_st = ale_pkg::ST_BAD_POS;
                                else begin
                                    n_tgt = CB'(i_cmd.position);
                                    n_i = CB'(i_cmd.position);
                                    n_state = (i_cmd.action ==
                                        ale_pkg::ACT_READ_AT) ? ale_pkg::S_READ
                                        : ale_pkg::S_SHDN_RD;
                                end
                            end
                            ale_pkg::ACT_DELETE_VAL, ale_pkg::ACT_SEARCH,
                            ale_pkg::ACT_INS_BEFORE: n_state = ale_pkg::S_SEARCH;
                            ale_pkg::ACT_INS_SORTED: begin
                                n_lim = r_count;
                                n_state = ale_pkg::S_SORT_INIT;
                            end
                            ale_pkg::ACT_DUMP, ale_pkg::ACT_DUMP_REV: begin
                                if (r_count != '0) n_state = ale_pkg::S_DUMP_RD;
                            end
                            default: n_state = ale_pkg::S_EMIT;
                        endcase
                    end
                end
            end
            // read r_i, compare next cycle
            ale_pkg::S_SEARCH: begin
                if (r_i >= r_count) begin
                    if (r_cmd.action == ale_pkg::ACT_INS_SORTED) begin
                        n_tgt = r_count; n_i = r_count;
                        n_state = ale_pkg::S_SHUP_RD;
                    end else begin
                        n_st = ale_pkg::ST_NOTFOUND; n_tgt = '0;
                        n_state = ale_pkg::S_EMIT;
                    end
                end else n_state = ale_pkg::S_MATCH;
            end
            ale_pkg::S_MATCH: begin
                if (r_cmd.action == ale_pkg::ACT_INS_SORTED) begin
                    // list is sorted: first entry not below the value
                    if (w_ge) begin
                        n_tgt = r_i; n_i = r_count; n_state = ale_pkg::S_SHUP_RD;
                    end else begin
                        n_i = r_i + 1'b1; n_state = ale_pkg::S_SEARCH;
                    end
                end else if (w_hit) begin
                    n_tgt = r_i;
                    if (r_cmd.action == ale_pkg::ACT_SEARCH) n_state = ale_pkg::S_EMIT;
                    else if (r_cmd.action == ale_pkg::ACT_DELETE_VAL)
                        n_state = ale_pkg::S_SHDN_RD;
                    else if (w_full) begin
                        n_st = ale_pkg::ST_FULL; n_tgt = '0;
                        n_state = ale_pkg::S_EMIT;
                    end else begin
                        n_i = r_count; n_state = ale_pkg::S_SHUP_RD;
                    end
                end else begin
                    n_i = r_i + 1'b1; n_state = ale_pkg::S_SEARCH;
                end
            end
            // bubble sort: pass over [0, r_lim), largest lands at r_lim-1
            ale_pkg::S_SORT_INIT: begin
                if (r_lim <= CB'(1)) begin
                    n_i = '0;
                    if (w_full) begin
                        n_st = ale_pkg::ST_FULL; n_tgt = '0;
                        n_state = ale_pkg::S_EMIT;
                    end else n_state = ale_pkg::S_SEARCH;
                end else n_state = ale_pkg::S_SORT_LD;
            end
            ale_pkg::S_SORT_LD: n_state = ale_pkg::S_SORT_CMP;
            ale_pkg::S_SORT_CMP: begin
                n_i = r_i + 1'b1;
                if (r_i + CB'(2) >= r_lim) n_state = ale_pkg::S_SORT_END;
            end
            ale_pkg::S_SORT_END: begin
                n_lim = r_lim - 1'b1; n_i = '0;
                n_state = ale_pkg::S_SORT_INIT;
            end
            ale_pkg::S_SHUP_RD: n_state = ale_pkg::S_SHUP_WR;
            ale_pkg::S_SHUP_WR: begin
                if (r_i == r_tgt) begin
                    n_count = r_count + 1'b1; n_state = ale_pkg::S_EMIT;
                end else begin
                    n_i = r_i - 1'b1; n_state = ale_pkg::S_SHUP_RD;
                end
            end
            ale_pkg::S_SHDN_RD: begin
                if (r_i + 1'b1 >= r_count) begin
                    n_count = r_count - 1'b1; n_state = ale_pkg::S_EMIT;
                end else n_state = ale_pkg::S_SHDN_WR;
            end
            ale_pkg::S_SHDN_WR: begin
                n_i = r_i + 1'b1; n_state = ale_pkg::S_SHDN_RD;
            end
            ale_pkg::S_READ: n_state = ale_pkg::S_EMIT;
            ale_pkg::S_DUMP_RD: n_state = ale_pkg::S_DUMP_OUT;
            ale_pkg::S_DUMP_OUT: begin
                if (w_oslot) begin
                    if (r_i + 1'b1 >= r_count) n_state = ale_pkg::S_IDLE;
                    else begin
                        n_i = r_i + 1'b1; n_state = ale_pkg::S_DUMP_RD;
                    end
                end
            end
            ale_pkg::S_EMIT: if (w_oslot) n_state = ale_pkg::S_IDLE;
            default: n_state = ale_pkg::S_IDLE;
        endcase
    end

    // memory and output controls
    always_comb begin
        w_we = 1'b0; w_wa = r_i[AB-1:0]; w_wd = r_rd; w_ra = r_i[AB-1:0];
        w_emit = 1'b0; w_es = r_st; w_ei = ale_pkg::IW'(r_tgt);
        w_ed = '0; w_el = 1'b1;
        case (r_state)
            ale_pkg::S_SORT_LD: w_ra = AB'(r_i + 1'b1);
            ale_pkg::S_SORT_CMP: begin
                // smaller of the pair stays behind, larger is carried on
                w_we = 1'b1; w_wa = r_i[AB-1:0];
                w_wd = w_less ? r_rd : r_hold;
                w_ra = AB'(r_i + CB'(2));
            end
            ale_pkg::S_SORT_END: begin
                w_we = 1'b1; w_wa = r_i[AB-1:0]; w_wd = r_hold;
            end
            ale_pkg::S_SHUP_RD: w_ra = AB'(r_i - 1'b1);
            ale_pkg::S_SHUP_WR: begin
                w_we = 1'b1; w_wa = r_i[AB-1:0];
                w_wd = (r_i == r_tgt) ? w_val : r_rd;
            end
            ale_pkg::S_SHDN_RD: w_ra = AB'(r_i + 1'b1);
            ale_pkg::S_SHDN_WR: begin
                w_we = 1'b1; w_wa = r_i[AB-1:0]; w_wd = r_rd;
            end
            ale_pkg::S_DUMP_RD: w_ra = w_dump_i[AB-1:0];
            ale_pkg::S_DUMP_OUT: begin
                // keep the address so a stalled word stays put
                w_ra = w_dump_i[AB-1:0];
                w_emit = w_oslot; w_es = ale_pkg::ST_OK;
                w_ei = ale_pkg::IW'(w_dump_i);
                w_ed = ale_pkg::VW'($signed(r_rd));
                w_el = (r_i + 1'b1 >= r_count);
            end
            ale_pkg::S_EMIT: begin
                w_emit = w_oslot;
                if (r_cmd.known && r_cmd.action == ale_pkg::ACT_READ_AT &&
                    r_st == ale_pkg::ST_OK)
                    w_ed = ale_pkg::VW'($signed(r_rd));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ale_pkg::S_IDLE && i_cmd_valid) r_cmd <= i_cmd;
        if (r_state == ale_pkg::S_SORT_LD) r_hold <= r_rd;
        else if (r_state == ale_pkg::S_SORT_CMP && !w_less) r_hold <= r_rd;
        if (w_emit) begin
            r_os <= w_es; r_oi <= w_ei; r_od <= w_ed; r_ol <= w_el;
            r_oc <= ale_pkg::PW'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ale_pkg::S_IDLE;
            r_count <= '0;
            r_i <= '0; r_lim <= '0; r_tgt <= '0;
            r_st <= ale_pkg::ST_OK;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count;
            r_i <= n_i; r_lim <= n_lim; r_tgt <= n_tgt;
            r_st <= n_st;
            if (w_emit) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end
endmodule

// File: rtl/array_list_engine_unit.sv
// ----------------------------------------------------------------------------
// array_list_engine_unit: ordered list of signed words with count
//
//  channel | signals                           | direction
//  in      | i_valid/o_ready, action..position | to block
//  out     | o_valid/i_ready, status..last     | from block
//
// Search, shifts and dumps walk the one-read-port element memory entry by
// entry, a read state then a compare, write or output state for each.
// Sorted insert first bubble sorts the list, then searches for its place.
// Synchronous active-low reset empties the list; memory is not cleared.
// A stalled result word holds the back end; the QDEPTH-entry queue keeps
// taking input until it fills.
// ----------------------------------------------------------------------------
module array_list_engine_unit #(
    parameter int DEPTH  = ale_pkg::DEPTH_DEF,
    parameter int WIDTH  = ale_pkg::WIDTH_DEF,
    parameter int QDEPTH = ale_pkg::QDEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [ale_pkg::AW-1:0] i_action,
    input  logic [ale_pkg::VW-1:0] i_value,
    input  logic [ale_pkg::VW-1:0] i_key,
    input  logic [ale_pkg::PW-1:0] i_position,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [ale_pkg::SW-1:0] o_status,
    output logic [ale_pkg::IW-1:0] o_index,
    output logic [ale_pkg::VW-1:0] o_data,
    output logic [ale_pkg::PW-1:0] o_count,
    output logic                   o_last
);
    logic          w_cv, w_cr;
    ale_pkg::t_cmd w_cmd;

    ale_front #(.QDEPTH(QDEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_action, .i_value, .i_key,
        .i_position, .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    ale_back #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cv), .o_cmd_ready(w_cr),
        .i_cmd(w_cmd), .o_valid, .i_ready, .o_status, .o_index, .o_data,
        .o_count, .o_last
    );
endmodule
